>>> rtl/core/cau_pkg.sv
package cau_pkg;

	localparam int FRAC = 16;
	localparam int QB = 34;
	localparam int NW = 64 + FRAC + 1;
	localparam int QD = 4;
	localparam int QAW = $clog2(QD);

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_NEG = 3'd4;
	localparam logic [2:0] FN_CNJ = 3'd5;
	localparam logic [2:0] FN_SQR = 3'd6;

	localparam logic signed [65:0] SMAX = 66'sd2147483647;
	localparam logic signed [65:0] SMIN = -66'sd2147483648;

	typedef enum logic [1:0] {
		K_SIMPLE = 2'd0,
		K_MUL    = 2'd1,
		K_DIV    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [2:0]        func;
		logic signed [31:0] ar;
		logic signed [31:0] ai;
		logic signed [31:0] br;
		logic signed [31:0] bi;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [32:0] sat66(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > SMAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < SMIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/cau_front.sv
module cau_front import cau_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,
	input  logic [127:0] s_tdata,
	input  qstat_t       qs,
	output logic         push,
	output item_t        item
);

	logic  f_vld_q;
	item_t item_q;
	item_t nxt;

	always_comb begin
		nxt.func = s_tuser;
		nxt.ar   = s_tdata[31:0];
		nxt.ai   = s_tdata[63:32];
		nxt.br   = s_tdata[95:64];
		nxt.bi   = s_tdata[127:96];
		case (s_tuser)
			FN_MUL: begin
				nxt.kind = K_MUL;
			end
			FN_SQR: begin
				nxt.kind = K_MUL;
				nxt.br   = s_tdata[31:0];
				nxt.bi   = s_tdata[63:32];
			end
			FN_DIV: begin
				nxt.kind = K_DIV;
			end
			default: begin
				nxt.kind = K_SIMPLE;
			end
		endcase
	end

	assign s_tready = !f_vld_q || !qs.full;
	assign push     = f_vld_q && !qs.full;
	assign item     = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_q <= 1'b0;
		end else if (s_tready) begin
			f_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q <= nxt;
		end
	end

endmodule

>>> rtl/core/cau_queue.sv
module cau_queue import cau_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  din,
	input  logic   pop,
	output item_t  dout,
	output qstat_t qs
);

	item_t          mem_q [QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign qs.full  = (cnt_q == (QAW+1)'(QD));
	assign qs.empty = (cnt_q == '0);
	assign dout     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QD)) else $error("queue count beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qs.full || pop)) else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty) else $error("queue read while empty");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("queue count slip");

endmodule

>>> rtl/core/cau_back.sv
module cau_back import cau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qstat_t      qs,
	input  item_t       din,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC - 1);

	logic adv;
	logic m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// Stage 1: products and the simple operations.
	logic               v_s1;
	kind_t              kind_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br_s1, p_bi_s1;
	logic [31:0]        sr_s1, si_s1;
	logic               sov_s1;

	// Stage 2: sums of products.
	logic               v_s2;
	kind_t              kind_s2;
	logic signed [64:0] mr_s2, mi_s2, dr_s2, di_s2;
	logic [63:0]        den_s2;
	logic [31:0]        sr_s2, si_s2;
	logic               sov_s2;

	// Stage 3 and the divider steps, index 0 being stage 3.
	logic        vld_s  [0:QB];
	kind_t       kind_s [0:QB];
	logic [31:0] r_s    [0:QB];
	logic [31:0] i_s    [0:QB];
	status_t     st_s   [0:QB];
	logic [63:0] den_s  [0:QB];
	logic        neg_s  [0:QB][2];
	logic        pov_s  [0:QB][2];
	logic [63:0] rem_s  [0:QB][2];
	logic [QB-1:0] low_s [0:QB][2];
	logic [QB-1:0] quo_s [0:QB][2];

	logic signed [32:0] s_r, s_i;
	logic [32:0]        sat_r, sat_i;
	logic signed [65:0] rnd_r, rnd_i;
	logic [32:0]        mul_r, mul_i;
	logic signed [64:0] dsum [2];
	logic [63:0]        mag  [2];
	logic [NW-1:0]      nv   [2];
	logic [63:0]        r0   [2];
	logic [64:0]        trial [1:QB][2];
	logic               take  [1:QB][2];
	logic [63:0]        nrem  [1:QB][2];
	logic [QB:0]        qinc [2];
	logic [QB-1:0]      qr   [2];
	logic [QB-1:0]      lim  [2];
	logic [QB-1:0]      qv   [2];
	logic               dov  [2];
	logic [31:0]        dres [2];
	logic [63:0]        o_data;
	status_t            o_st;

	assign adv      = !m_tvalid_q || m_tready;
	assign pop      = adv && !qs.empty;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		s_r = '0;
		s_i = '0;
		case (din.func)
			FN_ADD: begin
				s_r = {din.ar[31], din.ar} + {din.br[31], din.br};
				s_i = {din.ai[31], din.ai} + {din.bi[31], din.bi};
			end
			FN_SUB: begin
				s_r = {din.ar[31], din.ar} - {din.br[31], din.br};
				s_i = {din.ai[31], din.ai} - {din.bi[31], din.bi};
			end
			FN_NEG: begin
				s_r = 33'sd0 - {din.ar[31], din.ar};
				s_i = 33'sd0 - {din.ai[31], din.ai};
			end
			FN_CNJ: begin
				s_r = {din.ar[31], din.ar};
				s_i = 33'sd0 - {din.ai[31], din.ai};
			end
			default: begin
				s_r = '0;
				s_i = '0;
			end
		endcase
		sat_r = sat66($signed({{33{s_r[32]}}, s_r}));
		sat_i = sat66($signed({{33{s_i[32]}}, s_i}));
	end

	always_comb begin
		rnd_r = $signed({mr_s2[64], mr_s2}) + HALF;
		rnd_i = $signed({mi_s2[64], mi_s2}) + HALF;
		mul_r = sat66(rnd_r >>> FRAC);
		mul_i = sat66(rnd_i >>> FRAC);
		dsum[0] = dr_s2;
		dsum[1] = di_s2;
		for (int l = 0; l < 2; l++) begin
			mag[l] = dsum[l][64] ? 64'(-dsum[l]) : dsum[l][63:0];
			nv[l]  = {mag[l], (FRAC+1)'(0)};
			r0[l]  = 64'(nv[l][NW-1:QB]);
		end
	end

	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			for (int l = 0; l < 2; l++) begin
				trial[k][l] = {rem_s[k-1][l], low_s[k-1][l][QB-1]};
				take[k][l]  = trial[k][l] >= {1'b0, den_s[k-1]};
				nrem[k][l]  = take[k][l] ? 64'(trial[k][l] - {1'b0, den_s[k-1]})
				                         : trial[k][l][63:0];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qinc[l] = {1'b0, quo_s[QB][l]} + 1'b1;
			qr[l]   = qinc[l][QB:1];
			lim[l]  = neg_s[QB][l] ? QB'(34'h0_8000_0000) : QB'(34'h0_7FFF_FFFF);
			dov[l]  = pov_s[QB][l] || (qr[l] > lim[l]);
			qv[l]   = dov[l] ? lim[l] : qr[l];
			dres[l] = neg_s[QB][l] ? (~qv[l][31:0] + 32'd1) : qv[l][31:0];
		end
		if (kind_s[QB] == K_DIV) begin
			if (den_s[QB] == '0) begin
				o_data = '0;
				o_st   = ST_DIVZ;
			end else begin
				o_data = {dres[1], dres[0]};
				o_st   = (dov[0] || dov[1]) ? ST_OVF : ST_OK;
			end
		end else begin
			o_data = {i_s[QB], r_s[QB]};
			o_st   = st_s[QB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1       <= pop;
			v_s2       <= v_s1;
			vld_s[0]   <= v_s2;
			for (int k = 1; k <= QB; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			m_tvalid_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= din.kind;
			p_rr_s1 <= din.ar * din.br;
			p_ii_s1 <= din.ai * din.bi;
			p_ri_s1 <= din.ar * din.bi;
			p_ir_s1 <= din.ai * din.br;
			p_br_s1 <= din.br * din.br;
			p_bi_s1 <= din.bi * din.bi;
			sr_s1   <= sat_r[31:0];
			si_s1   <= sat_i[31:0];
			sov_s1  <= sat_r[32] || sat_i[32];

			kind_s2 <= kind_s1;
			mr_s2   <= $signed({p_rr_s1[63], p_rr_s1}) - $signed({p_ii_s1[63], p_ii_s1});
			mi_s2   <= $signed({p_ri_s1[63], p_ri_s1}) + $signed({p_ir_s1[63], p_ir_s1});
			dr_s2   <= $signed({p_rr_s1[63], p_rr_s1}) + $signed({p_ii_s1[63], p_ii_s1});
			di_s2   <= $signed({p_ir_s1[63], p_ir_s1}) - $signed({p_ri_s1[63], p_ri_s1});
			den_s2  <= $unsigned(p_br_s1) + $unsigned(p_bi_s1);
			sr_s2   <= sr_s1;
			si_s2   <= si_s1;
			sov_s2  <= sov_s1;

			kind_s[0] <= kind_s2;
			den_s[0]  <= den_s2;
			if (kind_s2 == K_MUL) begin
				r_s[0]  <= mul_r[31:0];
				i_s[0]  <= mul_i[31:0];
				st_s[0] <= (mul_r[32] || mul_i[32]) ? ST_OVF : ST_OK;
			end else begin
				r_s[0]  <= sr_s2;
				i_s[0]  <= si_s2;
				st_s[0] <= sov_s2 ? ST_OVF : ST_OK;
			end
			for (int l = 0; l < 2; l++) begin
				neg_s[0][l] <= dsum[l][64];
				pov_s[0][l] <= r0[l] >= den_s2;
				rem_s[0][l] <= r0[l];
				low_s[0][l] <= nv[l][QB-1:0];
				quo_s[0][l] <= '0;
			end

			for (int k = 1; k <= QB; k++) begin
				kind_s[k] <= kind_s[k-1];
				r_s[k]    <= r_s[k-1];
				i_s[k]    <= i_s[k-1];
				st_s[k]   <= st_s[k-1];
				den_s[k]  <= den_s[k-1];
				for (int l = 0; l < 2; l++) begin
					neg_s[k][l] <= neg_s[k-1][l];
					pov_s[k][l] <= pov_s[k-1][l];
					rem_s[k][l] <= nrem[k][l];
					low_s[k][l] <= {low_s[k-1][l][QB-2:0], 1'b0};
					quo_s[k][l] <= {quo_s[k-1][l][QB-2:0], take[k][l]};
				end
			end

			m_tdata_q <= o_data;
			m_tuser_q <= o_st;
		end
	end

endmodule

>>> rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed Q16.16 operands: add, subtract, multiply, divide, negate,
// conjugate and square, with saturation and a status word on every result. It accepts one
// word per cycle while the queue is not full and returns one result word per input word,
// in order; every word passes through the 34-stage restoring divider. An input register
// classifies each word and a four-entry queue separates it from the arithmetic pipeline,
// which halts as a whole while its output register holds an untaken result.
module complex_arithmetic_unit import cau_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // a_real, a_imag, b_real, b_imag
	input  logic [2:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // res_real, res_imag
	output logic [1:0]   m_tuser   // status
);

	qstat_t qs;
	logic   push;
	logic   pop;
	item_t  f_item;
	item_t  q_item;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.qs       (qs),
		.push     (push),
		.item     (f_item)
	);

	cau_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.pop    (pop),
		.dout   (q_item),
		.qs     (qs)
	);

	cau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qs       (qs),
		.din      (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
